>>> rtl/tbn_pkg.sv
// Shared types, constants and role functions for the tournament barrier node.
`default_nettype none

package tbn_pkg;

  localparam int unsigned MaxNodes      = 64;
  localparam int unsigned CapNodes      = (MaxNodes < 64) ? MaxNodes : 64;
  localparam int unsigned RoundMax      = 6;
  localparam int unsigned CmdQueueDepth = 2;

  // input command codes
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TOKEN   = 1'b1;

  // result action codes
  localparam logic ACT_SEND    = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // configuration register indexes
  localparam logic [0:0] CFG_NODE_ID    = 1'b0;
  localparam logic [0:0] CFG_NODE_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ROLE_WINNER,
    ROLE_LOSER,
    ROLE_BYE,
    ROLE_CHAMPION,
    ROLE_UNUSED
  } role_e;

  typedef struct packed {
    logic [5:0] node_id;
    logic [6:0] node_count;
  } cfg_t;

  typedef struct packed {
    logic       command;
    logic [5:0] from_node;
  } in_item_t;

  typedef struct packed {
    logic       action;
    logic [5:0] dest_node;
    logic       sense_bit;
    logic       last;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_token;
    logic [2:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic [6:0] eff_count(logic [6:0] cnt);
    logic [6:0] n;
    n = cnt;
    if (n == 7'd0) n = 7'd1;
    if (n > 7'(CapNodes)) n = 7'(CapNodes);
    return n;
  endfunction

  // smallest r with 2^r >= n
  function automatic logic [2:0] round_total(logic [6:0] n);
    logic [2:0] rt;
    rt = 3'd0;
    for (int r = 0; r <= 6; r++) begin
      if ((8'd1 << r) < {1'b0, n}) rt = rt + 3'd1;
    end
    return rt;
  endfunction

  function automatic role_e role_of(logic [5:0] id, logic [6:0] n, logic [2:0] k);
    logic [7:0] p;
    logic [7:0] h;
    logic [7:0] m;
    logic [7:0] sum;
    logic [7:0] nn;
    role_e      role;
    p   = 8'd1 << k;
    h   = p >> 1;
    m   = {2'b00, id} & (p - 8'd1);
    sum = {2'b00, id} + h;
    nn  = {1'b0, n};
    if (m == 8'd0 && sum < nn && p < nn)   role = ROLE_WINNER;
    else if (m == 8'd0 && sum >= nn)       role = ROLE_BYE;
    else if (m == h)                       role = ROLE_LOSER;
    else if (id == 6'd0 && p >= nn)        role = ROLE_CHAMPION;
    else                                   role = ROLE_UNUSED;
    return role;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tournament_barrier_node.sv
// Top level of the tournament barrier node: configuration, front end, queue and sequencer.
//
// Requests enter the front end, which takes one per cycle while the queue has room and tags
// each token with the round it belongs to; tokens that match no round are taken and dropped.
// The back-end sequencer takes one queued request at a time and dequeues it; an arrival climbs
// the rounds one by one, walks back down them and then emits the release, while a token that
// only marks a round is just recorded. Every result waits while the consumer holds off
// out_ready_i. Results leave through one output register, so the sequencer keeps working while
// a finished result waits, until it must emit another. Configuration must be written only
// while the block is idle; the block itself does not enforce this.
`default_nettype none

module tournament_barrier_node #(
  parameter int unsigned CMD_QUEUE_DEPTH = tbn_pkg::CmdQueueDepth
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [0:0]                cfg_index_i,
  input  wire [6:0]                cfg_wdata_i,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire tbn_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output tbn_pkg::out_item_t       out_data_o
);

  tbn_pkg::cfg_t         cfg_q, cfg_d;
  logic                  push;
  tbn_pkg::cmd_t         push_cmd;
  logic                  pop;
  tbn_pkg::cmd_t         pop_cmd;
  tbn_pkg::fifo_status_t fifo_status;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tbn_pkg::CFG_NODE_ID:    cfg_d.node_id    = cfg_wdata_i[5:0];
        tbn_pkg::CFG_NODE_COUNT: cfg_d.node_count = cfg_wdata_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id    <= 6'd0;
      cfg_q.node_count <= 7'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tbn_front u_front (
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .push_o        (push),
    .push_cmd_o    (push_cmd),
    .fifo_status_i (fifo_status)
  );

  tbn_cmd_fifo #(
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .status_o   (fifo_status)
  );

  tbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!fifo_status.empty),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("request pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("sequencer popped empty queue");

  a_release_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.action == tbn_pkg::ACT_RELEASE)
      |-> (out_data_o.last && out_data_o.dest_node == 6'd0))
    else $error("release result not final or has nonzero destination");

  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_status.full && fifo_status.empty))
    else $error("queue reports full and empty together");

endmodule

`default_nettype wire

>>> rtl/tbn_front.sv
// Front end: accepts requests and classifies tokens by the round they belong to.
`default_nettype none

module tbn_front (
  input  wire tbn_pkg::cfg_t         cfg_i,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  wire tbn_pkg::in_item_t     in_data_i,
  output logic                       push_o,
  output tbn_pkg::cmd_t              push_cmd_o,
  input  wire tbn_pkg::fifo_status_t fifo_status_i
);

  logic [6:0]    n;
  logic [2:0]    rt;
  logic [2:0]    hit;
  tbn_pkg::role_e role;
  logic [7:0]    h;
  logic [7:0]    up;
  logic [7:0]    dn;
  logic [7:0]    from;

  assign n    = tbn_pkg::eff_count(cfg_i.node_count);
  assign rt   = tbn_pkg::round_total(n);
  assign from = {2'b00, in_data_i.from_node};

  // lowest matching round wins; zero means no round matches
  always_comb begin
    hit  = 3'd0;
    role = tbn_pkg::ROLE_UNUSED;
    h    = 8'd0;
    up   = 8'd0;
    dn   = 8'd0;
    for (int k = tbn_pkg::RoundMax; k >= 1; k--) begin
      role = tbn_pkg::role_of(cfg_i.node_id, n, 3'(k));
      h    = 8'd1 << (k - 1);
      up   = {2'b00, cfg_i.node_id} + h;
      dn   = {2'b00, cfg_i.node_id} - h;
      if (3'(k) <= rt) begin
        if ((role == tbn_pkg::ROLE_WINNER || role == tbn_pkg::ROLE_CHAMPION) && up == from)
          hit = 3'(k);
        else if (role == tbn_pkg::ROLE_LOSER && dn == from)
          hit = 3'(k);
      end
    end
  end

  assign in_ready_o = !fifo_status_i.full;

  // tokens that match no round are taken and dropped
  assign push_o = in_valid_i && in_ready_o &&
                  (in_data_i.command == tbn_pkg::CMD_ARRIVAL || hit != 3'd0);

  always_comb begin
    push_cmd_o.is_token = (in_data_i.command == tbn_pkg::CMD_TOKEN);
    push_cmd_o.rnd      = hit;
  end

endmodule

`default_nettype wire

>>> rtl/tbn_cmd_fifo.sv
// Short request queue between the front end and the back-end sequencer.
`default_nettype none

module tbn_cmd_fifo #(
  parameter int unsigned DEPTH = tbn_pkg::CmdQueueDepth
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire tbn_pkg::cmd_t    push_cmd_i,
  input  wire                   pop_i,
  output tbn_pkg::cmd_t         pop_cmd_o,
  output tbn_pkg::fifo_status_t status_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  tbn_pkg::cmd_t        mem_q [DEPTH];
  logic [IdxW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push;
  logic                 do_pop;

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_cmd_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

`default_nettype wire

>>> rtl/tbn_back.sv
// Back-end sequencer: holds barrier state, climbs and descends rounds, emits results.
`default_nettype none

module tbn_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire tbn_pkg::cfg_t     cfg_i,
  input  wire                    cmd_valid_i,
  input  wire tbn_pkg::cmd_t     cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output tbn_pkg::out_item_t     out_data_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLIMB = 2'd1;
  localparam logic [1:0] ST_DESC  = 2'd2;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_TOKEN = 2'd1;
  localparam logic [1:0] PH_WAIT_WAKE  = 2'd2;

  logic [1:0]          st_q, st_d;
  logic [2:0]          rnd_q, rnd_d;
  logic [1:0]          phase_q, phase_d;
  logic [2:0]          cur_q, cur_d;
  logic [5:0]          pend_q, pend_d;
  logic                sense_q, sense_d;
  logic                out_valid_q, out_valid_d;
  tbn_pkg::out_item_t  out_q, out_d;

  logic [6:0]          n;
  logic [2:0]          rt;
  tbn_pkg::role_e      role;
  logic [7:0]          h;
  logic [7:0]          sum_up;
  logic [5:0]          dest_up;
  logic [5:0]          dest_dn;
  logic [5:0]          rmask;
  logic [5:0]          kmask;
  logic                pend_hit;
  logic                can_emit;
  logic                emit;
  logic                emit_action;
  logic [5:0]          emit_dest;
  logic                emit_last;

  assign n        = tbn_pkg::eff_count(cfg_i.node_count);
  assign rt       = tbn_pkg::round_total(n);
  assign role     = tbn_pkg::role_of(cfg_i.node_id, n, rnd_q);
  assign h        = 8'd1 << (rnd_q - 3'd1);
  assign sum_up   = {2'b00, cfg_i.node_id} + h;
  assign dest_up  = sum_up[5:0];
  assign dest_dn  = cfg_i.node_id - h[5:0];
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rmask[i] = (rnd_q == 3'(i + 1));
      kmask[i] = (cmd_i.rnd == 3'(i + 1));
    end
  end

  assign pend_hit = |(pend_q & rmask);

  always_comb begin
    st_d        = st_q;
    rnd_d       = rnd_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    pend_d      = pend_q;
    sense_d     = sense_q;
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    emit_action = tbn_pkg::ACT_SEND;
    emit_dest   = 6'd0;
    emit_last   = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.is_token == 1'b0) begin
            // arrival while busy is dropped
            if (phase_q == PH_IDLE) begin
              sense_d = ~sense_q;
              rnd_d   = 3'd1;
              st_d    = ST_CLIMB;
            end
          end else if (phase_q == PH_WAIT_WAKE && cur_q == cmd_i.rnd) begin
            pend_d = pend_q & ~kmask;
            rnd_d  = cmd_i.rnd - 3'd1;
            st_d   = ST_DESC;
          end else begin
            pend_d = pend_q | kmask;
            if (phase_q == PH_WAIT_TOKEN && cur_q == cmd_i.rnd) begin
              rnd_d = cmd_i.rnd;
              st_d  = ST_CLIMB;
            end
          end
        end
      end

      ST_CLIMB: begin
        if (rnd_q > rt) begin
          // climbed past the top without a final role
          rnd_d = rnd_q - 3'd1;
          st_d  = ST_DESC;
        end else begin
          case (role)
            tbn_pkg::ROLE_WINNER: begin
              if (pend_hit) begin
                pend_d = pend_q & ~rmask;
                rnd_d  = rnd_q + 3'd1;
              end else begin
                phase_d = PH_WAIT_TOKEN;
                cur_d   = rnd_q;
                st_d    = ST_IDLE;
              end
            end
            tbn_pkg::ROLE_CHAMPION: begin
              if (pend_hit) begin
                if (can_emit) begin
                  emit      = 1'b1;
                  emit_dest = dest_up;
                  pend_d    = pend_q & ~rmask;
                  rnd_d     = rnd_q - 3'd1;
                  st_d      = ST_DESC;
                end
              end else begin
                phase_d = PH_WAIT_TOKEN;
                cur_d   = rnd_q;
                st_d    = ST_IDLE;
              end
            end
            tbn_pkg::ROLE_LOSER: begin
              if (can_emit) begin
                emit      = 1'b1;
                emit_dest = dest_dn;
                if (pend_hit) begin
                  pend_d = pend_q & ~rmask;
                  rnd_d  = rnd_q - 3'd1;
                  st_d   = ST_DESC;
                end else begin
                  emit_last = 1'b1;
                  phase_d   = PH_WAIT_WAKE;
                  cur_d     = rnd_q;
                  st_d      = ST_IDLE;
                end
              end
            end
            default: begin
              rnd_d = rnd_q + 3'd1;
            end
          endcase
        end
      end

      ST_DESC: begin
        if (rnd_q == 3'd0) begin
          if (can_emit) begin
            emit        = 1'b1;
            emit_action = tbn_pkg::ACT_RELEASE;
            emit_last   = 1'b1;
            phase_d     = PH_IDLE;
            cur_d       = 3'd0;
            st_d        = ST_IDLE;
          end
        end else if (role == tbn_pkg::ROLE_WINNER) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_dest = dest_up;
            rnd_d     = rnd_q - 3'd1;
          end
        end else begin
          rnd_d = rnd_q - 3'd1;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (emit) begin
      out_valid_d     = 1'b1;
      out_d.action    = emit_action;
      out_d.dest_node = emit_dest;
      out_d.sense_bit = sense_q;
      out_d.last      = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rnd_q       <= 3'd0;
      phase_q     <= PH_IDLE;
      cur_q       <= 3'd0;
      pend_q      <= 6'd0;
      sense_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      rnd_q       <= rnd_d;
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      sense_q     <= sense_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the tournament barrier node: directed cases, then random ones.
`timescale 1ns / 1ps

module testbench;
  import tbn_pkg::*;

  localparam int unsigned SettleCycles   = 48;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned RandomRequests = 200;

  // barrier phase codes
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_TOKEN = 2'd1;
  localparam logic [1:0] PH_WAIT_WAKE  = 2'd2;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [0:0] cfg_index = CFG_NODE_ID;
  logic [6:0] cfg_wdata = 7'd0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;

  // predicted state of the node
  logic [5:0]  cfg_id         = 6'd0;
  logic [6:0]  cfg_count      = 7'd2;
  logic        sense          = 1'b0;
  logic [1:0]  barrier_phase  = PH_IDLE;
  int unsigned wait_round     = 0;
  logic [5:0]  pending_rounds = 6'd0;

  out_item_t   step_actions[$];
  out_item_t   awaited_actions[$];
  out_item_t   head_action;
  int unsigned effective_requests = 0;
  int unsigned error_count        = 0;
  int unsigned quiet_cycles       = 0;
  bit          calm               = 1'b0;
  int unsigned gap_odds           = 1;

  tournament_barrier_node i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned node_total();
    int unsigned n;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > CapNodes) n = CapNodes;
    return n;
  endfunction

  function automatic int unsigned round_count();
    int unsigned n;
    int unsigned r;
    n = node_total();
    r = 0;
    while (r < 7 && (1 << r) < n) r++;
    return r;
  endfunction

  function automatic role_e role_in_round(int unsigned k);
    int unsigned n;
    int unsigned p;
    int unsigned h;
    int unsigned m;
    n = node_total();
    p = 1 << k;
    h = p >> 1;
    m = cfg_id & (p - 1);
    if (m == 0 && cfg_id + h < n && p < n) return ROLE_WINNER;
    if (m == 0 && cfg_id + h >= n) return ROLE_BYE;
    if (m == h) return ROLE_LOSER;
    if (cfg_id == 0 && p >= n) return ROLE_CHAMPION;
    return ROLE_UNUSED;
  endfunction

  function automatic void push_action(logic act, int unsigned dest);
    step_actions.push_back(out_item_t'{action: act, dest_node: dest[5:0], sense_bit: sense,
                                       last: 1'b0});
  endfunction

  function automatic bit consume_round_token(int unsigned k);
    logic [5:0] mask;
    mask = 6'(1 << (k - 1));
    if ((pending_rounds & mask) != 6'd0) begin
      pending_rounds = pending_rounds & ~mask;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // wake the opponent of every round won below k, then release
  function automatic void wake_and_release(int unsigned k);
    int unsigned j;
    int unsigned r;
    for (j = k; j > 1; j--) begin
      r = j - 1;
      if (role_in_round(r) == ROLE_WINNER) push_action(ACT_SEND, cfg_id + (1 << (r - 1)));
    end
    push_action(ACT_RELEASE, 0);
    barrier_phase = PH_IDLE;
    wait_round    = 0;
  endfunction

  function automatic void climb_from(int unsigned start);
    int unsigned rt;
    int unsigned k;
    int unsigned h;
    role_e       role;
    rt = round_count();
    for (k = start; k <= rt && k <= 6; k++) begin
      h    = 1 << (k - 1);
      role = role_in_round(k);
      if (role == ROLE_WINNER) begin
        if (consume_round_token(k)) continue;
        barrier_phase = PH_WAIT_TOKEN;
        wait_round    = k;
        return;
      end
      if (role == ROLE_CHAMPION) begin
        if (consume_round_token(k)) begin
          push_action(ACT_SEND, cfg_id + h);
          wake_and_release(k);
          return;
        end
        barrier_phase = PH_WAIT_TOKEN;
        wait_round    = k;
        return;
      end
      if (role == ROLE_LOSER) begin
        push_action(ACT_SEND, cfg_id - h);
        if (consume_round_token(k)) begin
          wake_and_release(k);
          return;
        end
        barrier_phase = PH_WAIT_WAKE;
        wait_round    = k;
        return;
      end
    end
    wake_and_release(k);
  endfunction

  // returns 1 when the request changes the node's state
  function automatic bit barrier_step(in_item_t item);
    int unsigned rt;
    int unsigned k;
    int unsigned h;
    int unsigned hit;
    role_e       role;
    step_actions.delete();
    if (item.command == CMD_ARRIVAL) begin
      if (barrier_phase != PH_IDLE) return 1'b0;
      sense = ~sense;
      climb_from(1);
      return 1'b1;
    end
    rt  = round_count();
    hit = 0;
    for (k = 1; k <= rt && k <= 6; k++) begin
      h    = 1 << (k - 1);
      role = role_in_round(k);
      if ((role == ROLE_WINNER || role == ROLE_CHAMPION) && cfg_id + h == item.from_node) begin
        hit = k;
        break;
      end
      if (role == ROLE_LOSER && cfg_id - h == item.from_node) begin
        hit = k;
        break;
      end
    end
    if (hit == 0) return 1'b0;
    pending_rounds = pending_rounds | 6'(1 << (hit - 1));
    if (barrier_phase == PH_WAIT_TOKEN && wait_round == hit) begin
      climb_from(hit);
    end else if (barrier_phase == PH_WAIT_WAKE && wait_round == hit) begin
      void'(consume_round_token(hit));
      wake_and_release(hit);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input logic cmd, input logic [5:0] from);
    in_item_t    item;
    out_item_t   act;
    int unsigned gap;
    item.command   = cmd;
    item.from_node = from;
    gap = (!calm && $urandom_range(0, 3) < gap_odds) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (barrier_step(item)) effective_requests++;
    foreach (step_actions[i]) begin
      act      = step_actions[i];
      act.last = (i == step_actions.size() - 1);
      awaited_actions.push_back(act);
    end
  endtask

  // stop sending, let every predicted result come out, then let the node settle
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_actions.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] index, input logic [6:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == CFG_NODE_ID) cfg_id = value[5:0];
    else cfg_count = value;
  endtask

  // receiver stalls: windows of random stall density, some with none
  initial begin
    int unsigned window;
    int unsigned odds;
    int unsigned hold;
    window = 0;
    odds   = 0;
    forever begin
      @(negedge clk);
      if (window == 0) begin
        window = $urandom_range(20, 80);
        odds   = $urandom_range(0, 3);
      end
      window--;
      if (!calm && odds != 0 && $urandom_range(1, 8) <= odds) begin
        hold = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_actions.size() == 0) begin
        $error("unexpected result: %p", out_data);
        error_count++;
      end else begin
        head_action = awaited_actions.pop_front();
        if (out_data.action !== head_action.action) begin
          $error("action: expected %0d, got %0d", head_action.action, out_data.action);
          error_count++;
        end
        if (out_data.dest_node !== head_action.dest_node) begin
          $error("dest_node: expected %0d, got %0d", head_action.dest_node, out_data.dest_node);
          error_count++;
        end
        if (out_data.sense_bit !== head_action.sense_bit) begin
          $error("sense_bit: expected %0d, got %0d", head_action.sense_bit, out_data.sense_bit);
          error_count++;
        end
        if (out_data.last !== head_action.last) begin
          $error("last: expected %0d, got %0d", head_action.last, out_data.last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // reset settings: node 0 of 2 is champion of round one
  task automatic test_reset_config();
    send_request(CMD_ARRIVAL, 6'd0);
    send_request(CMD_ARRIVAL, 6'd63);  // busy, dropped
    send_request(CMD_TOKEN, 6'd5);     // matches no round
    send_request(CMD_TOKEN, 6'd1);
    wait_for_idle();
  endtask

  task automatic test_single_node();
    write_reg(CFG_NODE_COUNT, 7'd1);
    send_request(CMD_ARRIVAL, 6'd0);
    send_request(CMD_TOKEN, 6'd0);
    wait_for_idle();
    write_reg(CFG_NODE_COUNT, 7'd0);
    send_request(CMD_ARRIVAL, 6'd0);
    wait_for_idle();
  endtask

  // count above 64 is clipped; early tokens stay pending until their round
  task automatic test_full_climb();
    write_reg(CFG_NODE_ID, 7'd0);
    write_reg(CFG_NODE_COUNT, 7'd127);
    send_request(CMD_TOKEN, 6'd32);
    send_request(CMD_TOKEN, 6'd16);
    send_request(CMD_ARRIVAL, 6'd0);
    send_request(CMD_TOKEN, 6'd1);
    send_request(CMD_TOKEN, 6'd2);
    send_request(CMD_TOKEN, 6'd4);
    send_request(CMD_TOKEN, 6'd8);
    wait_for_idle();
  endtask

  task automatic test_loser_wake();
    write_reg(CFG_NODE_ID, 7'd63);
    write_reg(CFG_NODE_COUNT, 7'd64);
    send_request(CMD_ARRIVAL, 6'd63);
    send_request(CMD_TOKEN, 6'd0);
    send_request(CMD_TOKEN, 6'd62);
    // wake already held when the arrival comes
    send_request(CMD_TOKEN, 6'd62);
    send_request(CMD_ARRIVAL, 6'd0);
    wait_for_idle();
  endtask

  // id beyond the count: only byes, so release at once
  task automatic test_no_final_role();
    write_reg(CFG_NODE_ID, 7'd48);
    write_reg(CFG_NODE_COUNT, 7'd10);
    send_request(CMD_ARRIVAL, 6'd0);
    send_request(CMD_TOKEN, 6'd63);
    wait_for_idle();
  endtask

  task automatic test_random_episodes();
    int unsigned episodes;
    int unsigned k;
    int unsigned h;
    int unsigned n;
    role_e       role;
    logic [6:0]  count;
    episodes           = 0;
    effective_requests = 0;
    while (effective_requests < RandomRequests) begin
      if (episodes % 6 == 0) begin
        wait_for_idle();
        case ($urandom_range(0, 7))
          0:       count = 7'($urandom_range(0, 2));
          1:       count = 7'd64;
          2:       count = 7'($urandom_range(65, 127));
          default: count = 7'($urandom_range(1, 64));
        endcase
        n = (count > 64) ? 64 : count;
        write_reg(CFG_NODE_COUNT, count);
        if (n <= 1 || $urandom_range(0, 4) == 0) write_reg(CFG_NODE_ID, 7'($urandom_range(0, 63)));
        else write_reg(CFG_NODE_ID, 7'($urandom_range(0, n - 1)));
      end
      calm     = (effective_requests + 30 >= RandomRequests);
      gap_odds = $urandom_range(0, 2);
      // sometimes hand over a token before the local arrival
      if (round_count() > 0 && $urandom_range(0, 3) == 0) begin
        k    = $urandom_range(1, round_count());
        h    = 1 << (k - 1);
        role = role_in_round(k);
        if (role == ROLE_WINNER || role == ROLE_CHAMPION) send_request(CMD_TOKEN, 6'(cfg_id + h));
        else if (role == ROLE_LOSER) send_request(CMD_TOKEN, 6'(cfg_id - h));
      end
      send_request(CMD_ARRIVAL, 6'($urandom_range(0, 63)));
      while (barrier_phase != PH_IDLE) begin
        case ($urandom_range(0, 9))
          0: send_request(CMD_TOKEN, 6'($urandom_range(0, 63)));
          1: send_request(CMD_ARRIVAL, 6'($urandom_range(0, 63)));
          default: begin
            h = 1 << (wait_round - 1);
            send_request(CMD_TOKEN, (barrier_phase == PH_WAIT_TOKEN) ? 6'(cfg_id + h)
                                                                    : 6'(cfg_id - h));
          end
        endcase
      end
      episodes++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_config();
    test_single_node();
    test_full_climb();
    test_loser_wake();
    test_no_final_role();
    test_random_episodes();
    wait_for_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
